/* hw/rtl/cexu_pkg.sv */
// Shared types and constants for the 8-bit execute unit.
// Holds the operation codes, flag bit positions and the item structs.
// No dependencies.
package cexu_pkg;

  // Operation codes; codes above NOP behave as NOP.
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_BIT = 6'd2,
    OP_BCC = 6'd3,  OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BMI = 6'd6,
    OP_BNE = 6'd7,  OP_BPL = 6'd8,  OP_BVC = 6'd9,  OP_BVS = 6'd10,
    OP_CLC = 6'd11, OP_CLD = 6'd12, OP_CLI = 6'd13, OP_CLV = 6'd14,
    OP_CMP = 6'd15, OP_CPX = 6'd16, OP_CPY = 6'd17,
    OP_DEC = 6'd18, OP_DEX = 6'd19, OP_DEY = 6'd20, OP_EOR = 6'd21,
    OP_INC = 6'd22, OP_INX = 6'd23, OP_INY = 6'd24,
    OP_LDA = 6'd25, OP_LDX = 6'd26, OP_LDY = 6'd27, OP_ORA = 6'd28,
    OP_SBC = 6'd29, OP_SEC = 6'd30, OP_SED = 6'd31, OP_SEI = 6'd32,
    OP_STA = 6'd33, OP_STX = 6'd34, OP_STY = 6'd35,
    OP_TAX = 6'd36, OP_TAY = 6'd37, OP_TSX = 6'd38, OP_TXA = 6'd39,
    OP_TXS = 6'd40, OP_TYA = 6'd41, OP_NOP = 6'd42
  } kind_e;

  // Status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  operand;
    logic [15:0] program_counter;
    logic [15:0] mem_address;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  status_out;
    logic [15:0] next_pc;
    logic [1:0]  extra_cycles;
  } out_t;

  // Architectural register file
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] status;
  } regs_t;

  localparam regs_t REGS_RESET = '{
    acc: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFD, status: 8'h20
  };

  // Update N and Z in a status byte from a result byte
  function automatic logic [7:0] with_nz(logic [7:0] status, logic [7:0] value);
    logic [7:0] s;
    s = status;
    s[FLAG_N] = value[7];
    s[FLAG_Z] = (value == 8'h00);
    return s;
  endfunction

endpackage

/* hw/rtl/cexu_alu.sv */
// Combinational execute logic: one operation against the register file.
// Produces the next register file and the result item.
// Depends on cexu_pkg.
module cexu_alu (
  input  cexu_pkg::in_t   item_i,
  input  cexu_pkg::regs_t regs_i,
  output cexu_pkg::regs_t regs_o,
  output cexu_pkg::out_t  res_o
);
  import cexu_pkg::*;

  logic [7:0]  m;
  logic [7:0]  add_m;
  logic [8:0]  sum;
  logic [7:0]  cmp_r;
  logic [8:0]  diff;
  logic        cond;
  logic [15:0] target;
  logic [7:0]  st;
  logic [7:0]  a;

  assign m = item_i.operand;
  assign a = regs_i.acc;

  // Shared adder for ADC and SBC (SBC adds the inverted operand)
  assign add_m = (item_i.kind == OP_SBC) ? ~m : m;
  assign sum   = {1'b0, a} + {1'b0, add_m} + {8'h00, regs_i.status[FLAG_C]};

  // Shared comparator
  always_comb begin
    case (item_i.kind)
      OP_CPX:  cmp_r = regs_i.x;
      OP_CPY:  cmp_r = regs_i.y;
      default: cmp_r = a;
    endcase
  end
  assign diff = {1'b0, cmp_r} - {1'b0, m};

  // Branch condition and target
  always_comb begin
    case (item_i.kind)
      OP_BCC:  cond = !regs_i.status[FLAG_C];
      OP_BCS:  cond =  regs_i.status[FLAG_C];
      OP_BEQ:  cond =  regs_i.status[FLAG_Z];
      OP_BMI:  cond =  regs_i.status[FLAG_N];
      OP_BNE:  cond = !regs_i.status[FLAG_Z];
      OP_BPL:  cond = !regs_i.status[FLAG_N];
      OP_BVC:  cond = !regs_i.status[FLAG_V];
      OP_BVS:  cond =  regs_i.status[FLAG_V];
      default: cond = 1'b0;
    endcase
  end
  assign target = item_i.program_counter + {{8{m[7]}}, m};

  // Main decode
  always_comb begin
    regs_o = regs_i;
    st = regs_i.status;
    st[FLAG_U] = 1'b1;
    res_o = '0;
    res_o.next_pc = item_i.program_counter;

    unique case (item_i.kind)
      OP_ADC, OP_SBC: begin
        regs_o.acc = sum[7:0];
        st[FLAG_C] = sum[8];
        st[FLAG_V] = ~(a[7] ^ add_m[7]) & (a[7] ^ sum[7]);
        st = with_nz(st, sum[7:0]);
      end
      OP_AND: begin
        regs_o.acc = a & m;
        st = with_nz(st, a & m);
      end
      OP_BIT: begin
        st[FLAG_Z] = ((a & m) == 8'h00);
        st[FLAG_N] = m[7];
        st[FLAG_V] = m[6];
      end
      OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS: begin
        if (cond) begin
          res_o.next_pc = target;
          res_o.extra_cycles = (target[8] ^ item_i.program_counter[8]) ? 2'd2 : 2'd1;
        end
      end
      OP_CLC: st[FLAG_C] = 1'b0;
      OP_CLD: st[FLAG_D] = 1'b0;
      OP_CLI: st[FLAG_I] = 1'b0;
      OP_CLV: st[FLAG_V] = 1'b0;
      OP_CMP, OP_CPX, OP_CPY: begin
        st = with_nz(st, diff[7:0]);
        st[FLAG_C] = !diff[8];
      end
      OP_DEC: begin
        res_o.write_enable = 1'b1;
        res_o.write_data   = m - 8'd1;
        st = with_nz(st, m - 8'd1);
      end
      OP_INC: begin
        res_o.write_enable = 1'b1;
        res_o.write_data   = m + 8'd1;
        st = with_nz(st, m + 8'd1);
      end
      OP_DEX: begin
        regs_o.x = regs_i.x - 8'd1;
        st = with_nz(st, regs_i.x - 8'd1);
      end
      OP_DEY: begin
        regs_o.y = regs_i.y - 8'd1;
        st = with_nz(st, regs_i.y - 8'd1);
      end
      OP_INX: begin
        regs_o.x = regs_i.x + 8'd1;
        st = with_nz(st, regs_i.x + 8'd1);
      end
      OP_INY: begin
        regs_o.y = regs_i.y + 8'd1;
        st = with_nz(st, regs_i.y + 8'd1);
      end
      OP_EOR: begin
        regs_o.acc = a ^ m;
        st = with_nz(st, a ^ m);
      end
      OP_ORA: begin
        regs_o.acc = a | m;
        st = with_nz(st, a | m);
      end
      OP_LDA: begin
        regs_o.acc = m;
        st = with_nz(st, m);
      end
      OP_LDX: begin
        regs_o.x = m;
        st = with_nz(st, m);
      end
      OP_LDY: begin
        regs_o.y = m;
        st = with_nz(st, m);
      end
      OP_SEC: st[FLAG_C] = 1'b1;
      OP_SED: st[FLAG_D] = 1'b1;
      OP_SEI: st[FLAG_I] = 1'b1;
      OP_STA: begin
        res_o.write_enable = 1'b1;
        res_o.write_data   = a;
      end
      OP_STX: begin
        res_o.write_enable = 1'b1;
        res_o.write_data   = regs_i.x;
      end
      OP_STY: begin
        res_o.write_enable = 1'b1;
        res_o.write_data   = regs_i.y;
      end
      OP_TAX: begin
        regs_o.x = a;
        st = with_nz(st, a);
      end
      OP_TAY: begin
        regs_o.y = a;
        st = with_nz(st, a);
      end
      OP_TSX: begin
        regs_o.x = regs_i.sp;
        st = with_nz(st, regs_i.sp);
      end
      OP_TXA: begin
        regs_o.acc = regs_i.x;
        st = with_nz(st, regs_i.x);
      end
      OP_TXS: regs_o.sp = regs_i.x;
      OP_TYA: begin
        regs_o.acc = regs_i.y;
        st = with_nz(st, regs_i.y);
      end
      default: ;
    endcase

    regs_o.status = st;
    if (res_o.write_enable) begin
      res_o.write_address = item_i.mem_address;
    end
    res_o.acc_out    = regs_o.acc;
    res_o.x_out      = regs_o.x;
    res_o.y_out      = regs_o.y;
    res_o.sp_out     = regs_o.sp;
    res_o.status_out = st;
  end

endmodule

/* hw/rtl/cpu_execute_unit_8bit_top.sv */
// An accepted item passes the input register, then the result register; an output stall holds it.
// Throughput: one item per cycle while the output is not stalled; the register file is read and
// written in the execute stage, so each item sees the registers left by the one before it.
// Reset: A, X, Y cleared, SP = 0xFD, status = 0x20; both pipeline stages empty.
// Depends on cexu_pkg and cexu_alu.
module cpu_execute_unit_8bit_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cexu_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cexu_pkg::out_t out_data_o
);
  import cexu_pkg::*;

  logic  s1_valid_q;
  in_t   s1_item_q;
  regs_t regs_q, regs_d;
  out_t  res_d;
  out_t  out_q;
  logic  out_valid_q;
  logic  out_ready;
  logic  s1_fire;

  // Output stage can take a new item when empty or being drained
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  cexu_alu u_alu (
    .item_i (s1_item_q),
    .regs_i (regs_q),
    .regs_o (regs_d),
    .res_o  (res_d)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_data_i;
    end
  end

  // Register file: advance when the item moves into the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= REGS_RESET;
    end else if (s1_fire) begin
      regs_q <= regs_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Unused status bit is always set in a result
  a_unused_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status_out[FLAG_U])
    else $error("status bit 5 clear in result");

  // No write: address and data read as zero
  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.write_enable |->
      out_data_o.write_address == 16'h0000 && out_data_o.write_data == 8'h00)
    else $error("write fields nonzero without write");

  // The extra_cycles field never reaches 3
  a_extra_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.extra_cycles != 2'd3)
    else $error("extra cycles out of range");

  // Input stalls only when the input register holds an item that cannot move
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked item");

  // Register file holds while no item executes
  a_regs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(regs_q))
    else $error("register file changed without an item");

endmodule

/* sim/cpu_execute_unit_8bit_top_tb.sv */
// Self-checking testbench for cpu_execute_unit_8bit_top, the 8-bit execute stage.
// Predicts every result from its own register-file model and compares it field by field.
// Depends on cexu_pkg and the execute unit RTL.
`timescale 1ns / 1ps

module cpu_execute_unit_8bit_top_tb;
  import cexu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [5:0] KIND_UNDEF_LO = OP_NOP + 6'd1;
  localparam logic [5:0] KIND_UNDEF_HI = 6'h3F;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // Predicted architectural state
  logic [7:0] reg_a = 8'h00;
  logic [7:0] reg_x = 8'h00;
  logic [7:0] reg_y = 8'h00;
  logic [7:0] reg_sp = 8'hFD;
  logic [7:0] reg_p = 8'h20;

  out_t exec_results_q[$];
  int   mismatches = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   branches_taken = 0;
  int   page_crosses = 0;
  int   mem_writes = 0;
  int   cycle_count = 0;
  bit   no_idle = 1'b0;
  int   hold_req = 0;
  int   stall_run;
  out_t want;

  cpu_execute_unit_8bit_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               exec_results_q.size());
      $display("cpu_execute_unit_8bit_top verification failed");
      $finish;
    end
  end

  // Mostly no gap, some short gaps, a few long ones
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic void put_nz(logic [7:0] v);
    reg_p[FLAG_N] = v[7];
    reg_p[FLAG_Z] = (v == 8'h00);
  endfunction

  function automatic void put_compare(logic [7:0] r, logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    put_nz(d);
    reg_p[FLAG_C] = (r >= m);
  endfunction

  // Advance the predicted register file by one operation and return its result
  function automatic out_t exec_step(in_t it);
    out_t       r;
    logic [7:0] m;
    logic [7:0] addend;
    logic [8:0] sum;
    logic [15:0] target;
    logic       taken;
    r = '0;
    m = it.operand;
    taken = 1'b0;
    r.next_pc = it.program_counter;
    reg_p[FLAG_U] = 1'b1;
    case (it.kind)
      OP_ADC, OP_SBC: begin
        // binary only, D is ignored; subtract adds the complement
        addend = (it.kind == OP_SBC) ? ~m : m;
        sum = {1'b0, reg_a} + {1'b0, addend} + {8'h00, reg_p[FLAG_C]};
        reg_p[FLAG_C] = sum[8];
        reg_p[FLAG_V] = ~(reg_a[7] ^ addend[7]) & (reg_a[7] ^ sum[7]);
        reg_a = sum[7:0];
        put_nz(reg_a);
      end
      OP_AND: begin reg_a = reg_a & m; put_nz(reg_a); end
      OP_ORA: begin reg_a = reg_a | m; put_nz(reg_a); end
      OP_EOR: begin reg_a = reg_a ^ m; put_nz(reg_a); end
      OP_BIT: begin
        // N and V come straight from the operand
        reg_p[FLAG_Z] = ((reg_a & m) == 8'h00);
        reg_p[FLAG_N] = m[7];
        reg_p[FLAG_V] = m[6];
      end
      OP_BCC: taken = ~reg_p[FLAG_C];
      OP_BCS: taken = reg_p[FLAG_C];
      OP_BEQ: taken = reg_p[FLAG_Z];
      OP_BMI: taken = reg_p[FLAG_N];
      OP_BNE: taken = ~reg_p[FLAG_Z];
      OP_BPL: taken = ~reg_p[FLAG_N];
      OP_BVC: taken = ~reg_p[FLAG_V];
      OP_BVS: taken = reg_p[FLAG_V];
      OP_CLC: reg_p[FLAG_C] = 1'b0;
      OP_CLD: reg_p[FLAG_D] = 1'b0;
      OP_CLI: reg_p[FLAG_I] = 1'b0;
      OP_CLV: reg_p[FLAG_V] = 1'b0;
      OP_SEC: reg_p[FLAG_C] = 1'b1;
      OP_SED: reg_p[FLAG_D] = 1'b1;
      OP_SEI: reg_p[FLAG_I] = 1'b1;
      OP_CMP: put_compare(reg_a, m);
      OP_CPX: put_compare(reg_x, m);
      OP_CPY: put_compare(reg_y, m);
      OP_DEC: begin r.write_enable = 1'b1; r.write_data = m - 8'd1; put_nz(r.write_data); end
      OP_INC: begin r.write_enable = 1'b1; r.write_data = m + 8'd1; put_nz(r.write_data); end
      OP_STA: begin r.write_enable = 1'b1; r.write_data = reg_a; end
      OP_STX: begin r.write_enable = 1'b1; r.write_data = reg_x; end
      OP_STY: begin r.write_enable = 1'b1; r.write_data = reg_y; end
      OP_DEX: begin reg_x = reg_x - 8'd1; put_nz(reg_x); end
      OP_DEY: begin reg_y = reg_y - 8'd1; put_nz(reg_y); end
      OP_INX: begin reg_x = reg_x + 8'd1; put_nz(reg_x); end
      OP_INY: begin reg_y = reg_y + 8'd1; put_nz(reg_y); end
      OP_LDA: begin reg_a = m; put_nz(reg_a); end
      OP_LDX: begin reg_x = m; put_nz(reg_x); end
      OP_LDY: begin reg_y = m; put_nz(reg_y); end
      OP_TAX: begin reg_x = reg_a; put_nz(reg_x); end
      OP_TAY: begin reg_y = reg_a; put_nz(reg_y); end
      OP_TSX: begin reg_x = reg_sp; put_nz(reg_x); end
      OP_TXA: begin reg_a = reg_x; put_nz(reg_a); end
      OP_TYA: begin reg_a = reg_y; put_nz(reg_a); end
      OP_TXS: reg_sp = reg_x;
      default: ;
    endcase
    if (r.write_enable) begin
      r.write_address = it.mem_address;
      mem_writes++;
    end
    // Taken branch: wrap the target, and add one to extra_cycles on a page change
    if (taken) begin
      target = it.program_counter + {{8{m[7]}}, m};
      r.next_pc = target;
      r.extra_cycles = (target[8] != it.program_counter[8]) ? 2'd2 : 2'd1;
      branches_taken++;
      if (target[8] != it.program_counter[8]) page_crosses++;
    end
    r.acc_out = reg_a;
    r.x_out = reg_x;
    r.y_out = reg_y;
    r.sp_out = reg_sp;
    r.status_out = reg_p;
    return r;
  endfunction

  function automatic in_t make_item(logic [5:0] kind, logic [7:0] operand,
                                    logic [15:0] pc, logic [15:0] addr);
    in_t it;
    it.kind = kind;
    it.operand = operand;
    it.program_counter = pc;
    it.mem_address = addr;
    return it;
  endfunction

  // Random operation with extremes and page edges favored
  function automatic in_t random_item();
    in_t it;
    if ($urandom_range(0, 99) < 10)
      it.kind = 6'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
    else
      it.kind = 6'($urandom_range(OP_ADC, OP_NOP));
    if ($urandom_range(0, 99) < 20) begin
      case ($urandom_range(0, 4))
        0: it.operand = 8'h00;
        1: it.operand = 8'h01;
        2: it.operand = 8'h7F;
        3: it.operand = 8'h80;
        default: it.operand = 8'hFF;
      endcase
    end else begin
      it.operand = 8'($urandom_range(0, 255));
    end
    it.program_counter = 16'($urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 30)
      it.program_counter[7:0] = $urandom_range(0, 1) ? 8'($urandom_range(8'hF8, 8'hFF))
                                                     : 8'($urandom_range(8'h00, 8'h07));
    it.mem_address = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s = 0x%0h, predicted 0x%0h",
                                results_seen, field, got, exp_val));
  endtask

  // Offer one item, hold it until accepted, then record its prediction
  task automatic send_item(in_t item);
    int  idle;
    logic stalled;
    idle = no_idle ? 0 : pick_idle();
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    exec_results_q.push_back(exec_step(item));
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exec_results_q.size() != 0);
  endtask

  // Output stall: requested long hold-offs, otherwise random bursts
  always begin
    @(posedge clk_i);
    if (hold_req > 0) begin
      stall_run = hold_req;
      hold_req = 0;
      out_stall_i <= 1'b1;
      repeat (stall_run) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end else if (!no_idle && rst_ni && $urandom_range(0, 99) < 12) begin
      stall_run = pick_idle() + 1;
      out_stall_i <= 1'b1;
      repeat (stall_run) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction; inputs are stable at negedge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (exec_results_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing predicted", results_seen));
      end else begin
        want = exec_results_q.pop_front();
        check_field("write_enable", 16'(out_data_o.write_enable), 16'(want.write_enable));
        check_field("write_address", out_data_o.write_address, want.write_address);
        check_field("write_data", 16'(out_data_o.write_data), 16'(want.write_data));
        check_field("acc_out", 16'(out_data_o.acc_out), 16'(want.acc_out));
        check_field("x_out", 16'(out_data_o.x_out), 16'(want.x_out));
        check_field("y_out", 16'(out_data_o.y_out), 16'(want.y_out));
        check_field("sp_out", 16'(out_data_o.sp_out), 16'(want.sp_out));
        check_field("status_out", 16'(out_data_o.status_out), 16'(want.status_out));
        check_field("next_pc", out_data_o.next_pc, want.next_pc);
        check_field("extra_cycles", 16'(out_data_o.extra_cycles), 16'(want.extra_cycles));
      end
    end
  end

  // Reset status, decimal flag ignored by add and subtract, field extremes
  task automatic test_flags_and_arith();
    send_item(make_item(OP_NOP, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_SED, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_LDA, 8'h7F, 16'h0100, 16'h0000));
    send_item(make_item(OP_ADC, 8'h01, 16'h0200, 16'h0000));
    send_item(make_item(OP_SEC, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_SBC, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_CLD, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_CLC, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_ADC, 8'hFF, 16'h8000, 16'h8000));
  endtask

  // Bit test takes N and V from the operand; logic ops and compares at extremes
  task automatic test_bit_logic_compare();
    send_item(make_item(OP_BIT, 8'hC0, 16'h1234, 16'h0000));
    send_item(make_item(OP_BIT, 8'h00, 16'h1234, 16'h0000));
    send_item(make_item(OP_AND, 8'hFF, 16'h0000, 16'h0000));
    send_item(make_item(OP_EOR, 8'hFF, 16'h0000, 16'h0000));
    send_item(make_item(OP_CMP, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_CPX, 8'hFF, 16'h0000, 16'h0000));
  endtask

  // Stack transfer leaves flags alone; branches wrap around the address space
  task automatic test_stack_and_branch_wrap();
    send_item(make_item(OP_LDX, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_TXS, 8'hFF, 16'h0000, 16'h0000));
    send_item(make_item(OP_CLV, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_BVC, 8'h7F, 16'hFFF0, 16'h0000));
    send_item(make_item(OP_BEQ, 8'h80, 16'h0005, 16'h0000));
    send_item(make_item(OP_BVS, 8'h10, 16'h4000, 16'h0000));
  endtask

  // Memory writes at both address extremes, then undefined operation codes
  task automatic test_writes_and_undefined();
    send_item(make_item(OP_INC, 8'hFF, 16'h0000, 16'hFFFF));
    send_item(make_item(OP_DEC, 8'h00, 16'h0000, 16'h0000));
    send_item(make_item(OP_STA, 8'h00, 16'h0000, 16'h1234));
    send_item(make_item(KIND_UNDEF_HI, 8'hFF, 16'hFFFF, 16'hFFFF));
    send_item(make_item(KIND_UNDEF_LO, 8'h80, 16'h00FF, 16'h0000));
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_item(random_item());
  endtask

  // Back-to-back items with no gaps on either side
  task automatic test_streaming(int count);
    no_idle = 1'b1;
    repeat (count) send_item(random_item());
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Hold the output off for a long stretch while the input keeps offering items
  task automatic test_output_holdoff(int count);
    no_idle = 1'b1;
    hold_req = 120;
    repeat (count) send_item(random_item());
    wait_drained();
    no_idle = 1'b0;
  endtask

  // Bursts separated by a pause until every result has come out
  task automatic test_drain_pauses(int bursts, int count);
    repeat (bursts) begin
      repeat (count) send_item(random_item());
      wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_flags_and_arith();
    test_bit_logic_compare();
    test_stack_and_branch_wrap();
    test_writes_and_undefined();
    wait_drained();
    test_random_mix(700);
    test_streaming(200);
    test_output_holdoff(40);
    test_drain_pauses(6, 40);
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d items and %0d results: %0d taken branches, %0d page crossings,",
             items_sent, results_seen, branches_taken, page_crosses);
    $display("%0d memory writes, long output hold-off, streaming and drain pauses; %0d mismatches",
             mem_writes, mismatches);
    if (mismatches == 0) begin
      $display("cpu_execute_unit_8bit_top verification clean");
    end else begin
      $display("cpu_execute_unit_8bit_top verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cexu_pkg.sv
hw/rtl/cexu_alu.sv
hw/rtl/cpu_execute_unit_8bit_top.sv
sim/cpu_execute_unit_8bit_top_tb.sv
